// ----- rtl/gcc_pkg.sv -----
package gcc_pkg;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_RENDER = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_SHADOW  = 2'd1,
    MODE_OUTLINE = 2'd2,
    MODE_ALT     = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_GAP
  } state_t;

  localparam logic [11:0] WHITE_RGB  = 12'h0fff;
  localparam logic [3:0]  ALPHA_FULL = 4'hf;
  localparam int          RING_LAST  = 8;

  // One pass of a render: offset, colour choice, blend flag, end of list.
  typedef struct packed {
    logic [1:0] ox;
    logic [1:0] oy;
    logic       white;
    logic       blend;
    logic       last;
  } pass_t;

  typedef struct packed {
    logic  latch;
    logic  clr_step;
    logic  pass_init;
    logic  run;
    logic  load;
    logic  read;
    pass_t pass;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic pass_empty;
    logic run_last;
  } dp_sts_t;

  function automatic pass_t pass_desc(input logic [1:0] mode, input logic [3:0] k);
    pass_t p;
    p = '0;
    unique case (mode)
      MODE_SHADOW: begin
        if (k == 4'd0) begin
          p.ox = 2'd1; p.oy = 2'd1;
        end else begin
          p.white = 1'b1; p.blend = 1'b1; p.last = 1'b1;
        end
      end
      MODE_OUTLINE: begin
        case (k)
          4'd0: begin p.ox = 2'd0; p.oy = 2'd0; end
          4'd1: begin p.ox = 2'd1; p.oy = 2'd0; end
          4'd2: begin p.ox = 2'd2; p.oy = 2'd0; end
          4'd3: begin p.ox = 2'd0; p.oy = 2'd1; end
          4'd4: begin p.ox = 2'd2; p.oy = 2'd1; end
          4'd5: begin p.ox = 2'd0; p.oy = 2'd2; end
          4'd6: begin p.ox = 2'd1; p.oy = 2'd2; end
          4'd7: begin p.ox = 2'd2; p.oy = 2'd2; end
          default: begin p.ox = 2'd1; p.oy = 2'd1; end
        endcase
        p.blend = (k != 4'd0);
        p.white = (k >= 4'(RING_LAST));
        p.last  = (k >= 4'(RING_LAST));
      end
      default: begin
        p.white = 1'b1; p.last = 1'b1;
      end
    endcase
    return p;
  endfunction

  // (diff * a) / 15 truncated toward zero, plus dst, low nibble kept.
  // |diff * a| <= 225, so x * 137 >> 11 equals x / 15 on that range.
  function automatic logic [3:0] mix_nibble(input logic [3:0] src, input logic [3:0] dst,
                                             input logic [3:0] a);
    logic [4:0]  diff;
    logic        neg;
    logic [3:0]  mag_d;
    logic [7:0]  mag;
    logic [15:0] scaled;
    logic [3:0]  q;
    diff   = {1'b0, src} - {1'b0, dst};
    neg    = diff[4];
    mag_d  = neg ? 4'(-diff) : diff[3:0];
    mag    = 8'(mag_d) * 8'(a);
    scaled = 16'(mag) * 16'd137;
    q      = scaled[14:11];
    return (neg ? 4'(-q) : q) + dst;
  endfunction

endpackage

// ----- rtl/gcc_ctrl.sv -----
module gcc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [1:0]      opcode,
  input  logic [1:0]      mode,
  input  gcc_pkg::dp_sts_t sts,
  output gcc_pkg::dp_cmd_t cmd,
  output logic            busy
);
  import gcc_pkg::*;

  state_t     state_r, state_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic [3:0] k_r, k_nxt;
  logic       pend_r, pend_nxt;
  pass_t      cur;
  logic       acc;

  assign cur  = pass_desc(mode_r, k_r);
  assign busy = (state_r != ST_IDLE);
  assign acc  = start && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      mode_r  <= MODE_NORMAL;
      k_r     <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      k_r     <= k_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    k_nxt     = k_r;
    pend_nxt  = pend_r;
    unique case (state_r)
      ST_CLEAR: if (sts.clr_last) state_nxt = pend_r ? ST_SETUP : ST_IDLE;
      ST_IDLE: begin
        if (acc && opcode == OP_RENDER) begin
          state_nxt = ST_CLEAR;
          mode_nxt  = mode;
          k_nxt     = '0;
          pend_nxt  = 1'b1;
        end
      end
      ST_SETUP: begin
        if (!sts.pass_empty) state_nxt = ST_RUN;
        else if (cur.last) begin
          state_nxt = ST_IDLE;
          pend_nxt  = 1'b0;
        end else k_nxt = k_r + 4'd1;
      end
      ST_RUN: if (sts.run_last) state_nxt = ST_GAP;
      ST_GAP: begin
        if (cur.last) begin
          state_nxt = ST_IDLE;
          pend_nxt  = 1'b0;
        end else begin
          state_nxt = ST_SETUP;
          k_nxt     = k_r + 4'd1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.pass = cur;
    unique case (state_r)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE: begin
        cmd.latch = acc && (opcode == OP_RENDER);
        cmd.load  = acc && (opcode == OP_LOAD);
        cmd.read  = acc && (opcode == OP_READ);
      end
      ST_SETUP: cmd.pass_init = !sts.pass_empty;
      ST_RUN:   cmd.run = 1'b1;
      ST_GAP:   cmd.run = 1'b0;
      default:  cmd.run = 1'b0;
    endcase
  end

endmodule

// ----- rtl/gcc_dpath.sv -----
module gcc_dpath #(
  parameter int CELL_MAX  = 64,
  parameter int GLYPH_MAX = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  gcc_pkg::dp_cmd_t cmd,
  output gcc_pkg::dp_sts_t sts,
  input  logic [5:0]       row,
  input  logic [5:0]       col,
  input  logic [4:0]       coverage,
  input  logic [6:0]       cell_size,
  input  logic [6:0]       box_x_offset,
  input  logic [6:0]       box_y_offset,
  input  logic [6:0]       box_width,
  input  logic [6:0]       box_height,
  input  logic             cfg_we,
  input  logic [11:0]      cfg_data,
  output logic             out_valid,
  output logic [15:0]      out_pixel
);
  import gcc_pkg::*;

  localparam int CD  = CELL_MAX * CELL_MAX;
  localparam int GD  = GLYPH_MAX * GLYPH_MAX;
  localparam int CAW = $clog2(CD);
  localparam int GAW = $clog2(GD);
  localparam int CW  = $clog2(CELL_MAX + 1);
  localparam int GW  = $clog2(GLYPH_MAX + 1);
  localparam int SW  = ((CW > GW) ? CW : GW) + 3;

  logic [15:0] cell_mem [CD];
  logic [4:0]  glyph_mem [GD];

  logic [11:0]    shadow_r;
  logic [CAW-1:0] clr_cnt_r;
  logic [CW-1:0]  n_r, cx_r, cy_r;
  logic [GW-1:0]  bw_r, bh_r;
  logic [6:0]     bx_r, by_r;
  logic           s1_vld_r, s1_in_r, s1_white_r, s1_blend_r;
  logic [CAW-1:0] s1_addr_r;
  logic           rd_ok_r;
  logic [15:0]    cell_q_r;
  logic [4:0]     glyph_q_r;

  logic [CW-1:0]  dy, dx, n_m1;
  logic [SW-1:0]  ly, lx;
  logic           in_box;
  logic [CAW-1:0] s0_addr, rd_addr, cra, cwa;
  logic [GAW-1:0] s0_gaddr, ld_addr;
  logic           rd_ok, ld_ok, cwe;
  logic [15:0]    cwd;
  logic [4:0]     s, a;
  logic [11:0]    color;
  logic [15:0]    d, blended;
  logic           s1_we;
  logic [15:0]    s1_wd;

  assign n_m1 = n_r - CW'(1);
  assign dy   = cy_r - CW'(cmd.pass.oy);
  assign dx   = cx_r - CW'(cmd.pass.ox);
  assign ly   = SW'(dy) - {{(SW-7){by_r[6]}}, by_r};
  assign lx   = SW'(dx) - {{(SW-7){bx_r[6]}}, bx_r};
  assign in_box = !ly[SW-1] && !lx[SW-1] && (ly < SW'(bh_r)) && (lx < SW'(bw_r));
  assign s0_addr  = CAW'(cy_r) * CAW'(CELL_MAX) + CAW'(cx_r);
  assign s0_gaddr = GAW'(ly[GW-1:0]) * GAW'(GLYPH_MAX) + GAW'(lx[GW-1:0]);

  assign rd_ok   = (32'(row) < CELL_MAX) && (32'(col) < CELL_MAX);
  assign ld_ok   = (32'(row) < GLYPH_MAX) && (32'(col) < GLYPH_MAX);
  assign rd_addr = CAW'(row) * CAW'(CELL_MAX) + CAW'(col);
  assign ld_addr = GAW'(row) * GAW'(GLYPH_MAX) + GAW'(col);

  assign sts.clr_last   = (clr_cnt_r == CAW'(CD - 1));
  assign sts.pass_empty = (n_r <= CW'(cmd.pass.ox)) || (n_r <= CW'(cmd.pass.oy));
  assign sts.run_last   = (cx_r == n_m1) && (cy_r == n_m1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shadow_r  <= '0;
      clr_cnt_r <= '0;
      s1_vld_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) shadow_r <= cfg_data;
      if (cmd.latch) clr_cnt_r <= '0;
      else if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + CAW'(1);
      s1_vld_r  <= cmd.run;
      out_valid <= cmd.read;
    end
  end

  // render parameters, pixel walk and pipeline payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      n_r  <= (32'(cell_size) > CELL_MAX) ? CW'(CELL_MAX) : CW'(cell_size);
      bw_r <= (32'(box_width) > GLYPH_MAX) ? GW'(GLYPH_MAX) : GW'(box_width);
      bh_r <= (32'(box_height) > GLYPH_MAX) ? GW'(GLYPH_MAX) : GW'(box_height);
      bx_r <= box_x_offset;
      by_r <= box_y_offset;
    end
    if (cmd.pass_init) begin
      cx_r <= CW'(cmd.pass.ox);
      cy_r <= CW'(cmd.pass.oy);
    end else if (cmd.run) begin
      if (cx_r == n_m1) begin
        cx_r <= CW'(cmd.pass.ox);
        cy_r <= cy_r + CW'(1);
      end else cx_r <= cx_r + CW'(1);
    end
    s1_in_r    <= in_box;
    s1_addr_r  <= s0_addr;
    s1_white_r <= cmd.pass.white;
    s1_blend_r <= cmd.pass.blend;
    rd_ok_r    <= rd_ok;
  end

  // pass rule on the sample and the old pixel
  always_comb begin
    s     = s1_in_r ? glyph_q_r : 5'd0;
    a     = s - 5'd1;
    color = s1_white_r ? WHITE_RGB : shadow_r;
    d     = cell_q_r;
    blended = {((a[3:0] > d[15:12]) ? a[3:0] : d[15:12]),
               mix_nibble(color[11:8], d[11:8], a[3:0]),
               mix_nibble(color[7:4],  d[7:4],  a[3:0]),
               mix_nibble(color[3:0],  d[3:0],  a[3:0])};
    if (s == 5'd0) begin
      s1_we = !s1_blend_r;
      s1_wd = '0;
    end else if (s1_blend_r && a < 5'(ALPHA_FULL)) begin
      s1_we = (a != 5'd0);
      s1_wd = blended;
    end else begin
      s1_we = 1'b1;
      s1_wd = {a[3:0], color};
    end
  end

  assign cra = cmd.run ? s0_addr : rd_addr;
  assign cwe = cmd.clr_step || (s1_vld_r && s1_we);
  assign cwa = cmd.clr_step ? clr_cnt_r : s1_addr_r;
  assign cwd = cmd.clr_step ? 16'd0 : s1_wd;

  always_ff @(posedge clk) begin
    if (cwe) cell_mem[cwa] <= cwd;
    cell_q_r <= cell_mem[cra];
  end

  always_ff @(posedge clk) begin
    if (cmd.load && ld_ok) glyph_mem[ld_addr] <= coverage;
    glyph_q_r <= glyph_mem[s0_gaddr];
  end

  assign out_pixel = rd_ok_r ? cell_q_r : 16'd0;

endmodule

// ----- rtl/glyph_cell_compositor.sv -----
// Loads and reads are taken while idle; a read result appears in the cycle after its beat.
// Result beats cannot be stalled by the receiver.
// A render clears the cell store, then runs one to nine passes of the mode;
// a non-empty pass walks (n-ox)*(n-oy) pixels and an empty pass is skipped.
// Busy holds input off for the whole render; the single cell store write port sets the rate.
// Reset (rst_n low, synchronous) starts a clear of all CELL_MAX*CELL_MAX cell store entries.
module glyph_cell_compositor #(
  parameter int CELL_MAX  = 64,
  parameter int GLYPH_MAX = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [5:0]  in_row,
  input  logic [5:0]  in_col,
  input  logic [4:0]  in_coverage,
  input  logic [1:0]  in_mode,
  input  logic [6:0]  in_cell_size,
  input  logic signed [6:0] in_box_x_offset,
  input  logic signed [6:0] in_box_y_offset,
  input  logic [6:0]  in_box_width,
  input  logic [6:0]  in_box_height,
  output logic        out_valid,
  output logic [15:0] out_pixel,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data
);
  import gcc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // the user must write the register only while idle; the block does not enforce it, so always take the beat
  assign cfg_ready = 1'b1;

  // sequencer: clear sweep, then each pass of the chosen mode
  gcc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (in_opcode),
    .mode   (in_mode),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  // stores, pixel walk and blend pipeline
  gcc_dpath #(
    .CELL_MAX  (CELL_MAX),
    .GLYPH_MAX (GLYPH_MAX)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .row          (in_row),
    .col          (in_col),
    .coverage     (in_coverage),
    .cell_size    (in_cell_size),
    .box_x_offset (in_box_x_offset),
    .box_y_offset (in_box_y_offset),
    .box_width    (in_box_width),
    .box_height   (in_box_height),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_pixel    (out_pixel)
  );

  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_opcode == OP_READ))
    else $error("result beat without a read beat");

  a_render_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode == OP_RENDER) |=> busy)
    else $error("render did not raise busy");

  a_reset_clear: assert property (@(posedge clk)
    $rose(rst_n) |-> busy)
    else $error("no clear sweep after reset");

  a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(busy) |-> !out_valid)
    else $error("result while rendering");

endmodule
